/* rtl/gscm_pkg.sv */
`timescale 1ns / 1ps
// gscm_pkg: shared types and constants for the gyro SPI command master
// no dependencies; used by the channel interfaces and the core

package gscm_pkg;

  // frame and counter sizes
  localparam int FRAME_BITS = 32;
  localparam int WAIT_WIDTH = 24;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS) + 1;
  localparam int HALF_W     = 16;
  localparam int SHORT_W    = 16;
  localparam int LONG_W     = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int FIDX_W     = 3;

  // command codes
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_READ    = 3'd2,
    CMD_RATE    = 3'd3,
    CMD_STARTUP = 3'd4
  } cmd_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP    = 2'd2;

  // fixed command words
  localparam logic [FRAME_BITS-1:0] WORD_WRITE    = 32'h4000_0000;
  localparam logic [FRAME_BITS-1:0] WORD_READ     = 32'h8000_0000;
  localparam logic [FRAME_BITS-1:0] WORD_RATE     = 32'h2000_0000;
  localparam logic [FRAME_BITS-1:0] WORD_STARTUP0 = 32'h2000_0003;
  localparam int ADDR_LSB = 17;
  localparam int DATA_LSB = 1;

  // reset values of the configuration registers
  localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd50;
  localparam logic [SHORT_W-1:0] SHORT_RESET = 16'd50;
  localparam logic [LONG_W-1:0]  LONG_RESET  = 24'd50000;

  // bit positions of the extracted read values
  localparam int REG_VALUE_LSB  = 5;
  localparam int RATE_VALUE_LSB = 10;

  // frame sequencer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SETUP = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_GAP   = 5'b10000
  } phase_t;

endpackage

/* rtl/gscm_in_if.sv */
`timescale 1ns / 1ps
// gscm_in_if: tick/command channel into the gyro SPI command master
// depends on gscm_pkg

interface gscm_in_if import gscm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  reg_address;
  logic [15:0] write_data;
  logic        miso;

  modport source (output valid, cmd, reg_address, write_data, miso, input ready);
  modport sink   (input valid, cmd, reg_address, write_data, miso, output ready);
endinterface

/* rtl/gscm_out_if.sv */
`timescale 1ns / 1ps
// gscm_out_if: per-tick result channel of the gyro SPI command master
// depends on gscm_pkg

interface gscm_out_if import gscm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cs_n;
  logic                  sck;
  logic                  mosi;
  logic                  busy_res;
  logic                  done_res;
  logic [15:0]           read_value;
  logic [FRAME_BITS-1:0] raw_response;

  modport source (output valid, cs_n, sck, mosi, busy_res, done_res, read_value,
                  raw_response, input ready);
  modport sink   (input valid, cs_n, sck, mosi, busy_res, done_res, read_value,
                  raw_response, output ready);
endinterface

/* rtl/gscm_cfg_if.sv */
`timescale 1ns / 1ps
// gscm_cfg_if: configuration write channel of the gyro SPI command master
// depends on gscm_pkg

interface gscm_cfg_if import gscm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/gyro_spi_command_master_core.sv */
`timescale 1ns / 1ps
// gyro_spi_command_master_core: 32-bit mode 0 SPI master running sensor command sequences
// depends on gscm_pkg, gscm_in_if, gscm_out_if, gscm_cfg_if
//
//  channel   dir  handshake      carries
//  in_chan   in   valid/ready    cmd, reg_address, write_data, miso (one tick each)
//  out_chan  out  valid/ready    pins, busy, done, read_value, raw_response
//  cfg_chan  in   valid/ready    reg_index, wdata (ready always high)
//
// one input transfer per cycle while in_chan.ready is high; its result is registered and shown the next cycle
// in_chan.ready drops only while a result waits in the output register unread
// the sequencer state and the result register advance together on an input transfer
// rst_n is synchronous: idle phase, chip select high, output register empty

module gyro_spi_command_master_core import gscm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gscm_in_if.sink    in_chan,
  gscm_out_if.source out_chan,
  gscm_cfg_if.sink   cfg_chan
);

  // configuration registers
  logic [HALF_W-1:0]  half_r;
  logic [SHORT_W-1:0] short_r;
  logic [LONG_W-1:0]  long_r;

  // sequencer state
  phase_t                phase_r, phase_nxt;
  logic [2:0]            act_cmd_r, act_cmd_nxt;
  logic [FIDX_W-1:0]     fidx_r, fidx_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [WAIT_WIDTH-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [FRAME_BITS-1:0] tx_shift_r, tx_shift_nxt;
  logic [FRAME_BITS-1:0] rx_shift_r, rx_shift_nxt;
  logic [FRAME_BITS-1:0] frame_word_r, frame_word_nxt;
  logic                  cs_n_r, cs_n_nxt;
  logic                  sck_r, sck_nxt;
  logic                  mosi_r, mosi_nxt;

  // output register
  logic                  out_valid_r;
  logic                  o_cs_n_r, o_sck_r, o_mosi_r, o_busy_r, o_done_r;
  logic [15:0]           o_read_r;
  logic [FRAME_BITS-1:0] o_raw_r;

  logic                  in_xfer;
  logic                  done;
  logic                  start;
  logic [FRAME_BITS-1:0] start_word;
  logic [FIDX_W-1:0]     fidx_inc;
  logic [2:0]            n_frames;
  logic [15:0]           read_val;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_RESET;
      short_r <= SHORT_RESET;
      long_r  <= LONG_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        CFG_HALF_PERIOD: half_r  <= cfg_chan.wdata[HALF_W-1:0];
        CFG_SHORT_GAP:   short_r <= cfg_chan.wdata[SHORT_W-1:0];
        CFG_LONG_GAP:    long_r  <= cfg_chan.wdata[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  // frames in the active sequence
  always_comb begin
    case (act_cmd_r)
      CMD_READ:    n_frames = 3'd2;
      CMD_STARTUP: n_frames = 3'd4;
      default:     n_frames = 3'd1;
    endcase
  end

  assign fidx_inc = fidx_r + 1'b1;

  // one tick of the sequencer
  always_comb begin
    phase_nxt      = phase_r;
    act_cmd_nxt    = act_cmd_r;
    fidx_nxt       = fidx_r;
    bit_cnt_nxt    = bit_cnt_r;
    wait_cnt_nxt   = wait_cnt_r;
    tx_shift_nxt   = tx_shift_r;
    rx_shift_nxt   = rx_shift_r;
    frame_word_nxt = frame_word_r;
    cs_n_nxt       = cs_n_r;
    sck_nxt        = sck_r;
    mosi_nxt       = mosi_r;
    done           = 1'b0;
    start          = 1'b0;
    start_word     = frame_word_r;

    if (phase_r == PH_IDLE) begin
      act_cmd_nxt = in_chan.cmd;
      fidx_nxt    = '0;
      start       = 1'b1;
      unique case (in_chan.cmd)
        CMD_WRITE: begin
          frame_word_nxt = WORD_WRITE
                         | (FRAME_BITS'(in_chan.reg_address) << ADDR_LSB)
                         | (FRAME_BITS'(in_chan.write_data) << DATA_LSB);
          start_word = frame_word_nxt;
        end
        CMD_READ: begin
          frame_word_nxt = WORD_READ | (FRAME_BITS'(in_chan.reg_address) << ADDR_LSB);
          start_word = frame_word_nxt;
        end
        CMD_RATE: begin
          frame_word_nxt = WORD_RATE;
          start_word = WORD_RATE;
        end
        CMD_STARTUP: begin
          frame_word_nxt = WORD_RATE;
          start_word = WORD_STARTUP0;
        end
        default: begin
          // no command or unused code: stay idle
          act_cmd_nxt = act_cmd_r;
          fidx_nxt    = fidx_r;
          start       = 1'b0;
        end
      endcase
    end else if (wait_cnt_r > WAIT_WIDTH'(1)) begin
      wait_cnt_nxt = wait_cnt_r - 1'b1;
    end else begin
      unique case (phase_r)
        PH_SETUP: begin
          // rising edge, sample miso
          sck_nxt      = 1'b1;
          rx_shift_nxt = {rx_shift_r[FRAME_BITS-2:0], in_chan.miso};
          bit_cnt_nxt  = bit_cnt_r + 1'b1;
          wait_cnt_nxt = WAIT_WIDTH'(half_r);
          phase_nxt    = PH_HIGH;
        end
        PH_HIGH: begin
          // falling edge, set up next bit
          sck_nxt      = 1'b0;
          mosi_nxt     = tx_shift_r[FRAME_BITS-1];
          tx_shift_nxt = tx_shift_r << 1;
          wait_cnt_nxt = WAIT_WIDTH'(half_r);
          phase_nxt    = PH_LOW;
        end
        PH_LOW: begin
          if (bit_cnt_r < BIT_CNT_W'(FRAME_BITS)) begin
            sck_nxt      = 1'b1;
            rx_shift_nxt = {rx_shift_r[FRAME_BITS-2:0], in_chan.miso};
            bit_cnt_nxt  = bit_cnt_r + 1'b1;
            wait_cnt_nxt = WAIT_WIDTH'(half_r);
            phase_nxt    = PH_HIGH;
          end else begin
            // end of frame: release chip select, then gap or finish
            cs_n_nxt = 1'b1;
            mosi_nxt = 1'b0;
            if (act_cmd_r == CMD_STARTUP) begin
              wait_cnt_nxt = (fidx_r == '0) ? WAIT_WIDTH'(short_r) : WAIT_WIDTH'(long_r);
              phase_nxt    = PH_GAP;
            end else if (act_cmd_r == CMD_READ && fidx_r == '0) begin
              wait_cnt_nxt = WAIT_WIDTH'(short_r);
              phase_nxt    = PH_GAP;
            end else begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end
        end
        PH_GAP: begin
          fidx_nxt = fidx_inc;
          if (3'(fidx_inc) < n_frames) begin
            start = 1'b1;
            if (act_cmd_r == CMD_STARTUP) begin
              start_word = (fidx_inc == '0) ? WORD_STARTUP0 : WORD_RATE;
            end
          end else begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // frame start: chip select low, msb on mosi
    if (start) begin
      cs_n_nxt     = 1'b0;
      sck_nxt      = 1'b0;
      mosi_nxt     = start_word[FRAME_BITS-1];
      tx_shift_nxt = start_word << 1;
      rx_shift_nxt = '0;
      bit_cnt_nxt  = '0;
      wait_cnt_nxt = WAIT_WIDTH'(half_r);
      phase_nxt    = PH_SETUP;
    end
  end

  // extracted value on completion
  always_comb begin
    read_val = '0;
    if (done) begin
      case (act_cmd_r)
        CMD_READ: read_val = rx_shift_r[REG_VALUE_LSB +: 16];
        CMD_RATE: read_val = rx_shift_r[RATE_VALUE_LSB +: 16];
        default:  read_val = '0;
      endcase
    end
  end

  // sequencer registers advance once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      act_cmd_r    <= '0;
      fidx_r       <= '0;
      bit_cnt_r    <= '0;
      wait_cnt_r   <= '0;
      tx_shift_r   <= '0;
      rx_shift_r   <= '0;
      frame_word_r <= '0;
      cs_n_r       <= 1'b1;
      sck_r        <= 1'b0;
      mosi_r       <= 1'b0;
    end else if (in_xfer) begin
      phase_r      <= phase_nxt;
      act_cmd_r    <= act_cmd_nxt;
      fidx_r       <= fidx_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      tx_shift_r   <= tx_shift_nxt;
      rx_shift_r   <= rx_shift_nxt;
      frame_word_r <= frame_word_nxt;
      cs_n_r       <= cs_n_nxt;
      sck_r        <= sck_nxt;
      mosi_r       <= mosi_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      o_cs_n_r <= cs_n_nxt;
      o_sck_r  <= sck_nxt;
      o_mosi_r <= mosi_nxt;
      o_busy_r <= (phase_nxt != PH_IDLE);
      o_done_r <= done;
      o_read_r <= read_val;
      o_raw_r  <= done ? rx_shift_r : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.cs_n         = o_cs_n_r;
  assign out_chan.sck          = o_sck_r;
  assign out_chan.mosi         = o_mosi_r;
  assign out_chan.busy_res     = o_busy_r;
  assign out_chan.done_res     = o_done_r;
  assign out_chan.read_value   = o_read_r;
  assign out_chan.raw_response = o_raw_r;

  // a valid command taken while idle starts a frame
  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && phase_r == PH_IDLE &&
    (in_chan.cmd == CMD_WRITE || in_chan.cmd == CMD_READ ||
     in_chan.cmd == CMD_RATE || in_chan.cmd == CMD_STARTUP)
    |=> phase_r == PH_SETUP && !cs_n_r)
    else $error("command accepted while idle did not start a frame");

  // chip select is low throughout the bit phases
  a_cs_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETUP || phase_r == PH_HIGH || phase_r == PH_LOW) |-> !cs_n_r)
    else $error("chip select high inside a frame");

  // sck is high only in the high half period
  a_sck_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sck_r |-> phase_r == PH_HIGH)
    else $error("sck high outside the high phase");

  // a done result always reports the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && done |=> out_valid_r && o_done_r && !o_busy_r && phase_r == PH_IDLE)
    else $error("done result without idle sequencer");

  // the state holds while no transfer is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(phase_r) && $stable(wait_cnt_r) && $stable(bit_cnt_r))
    else $error("sequencer state moved without an input transfer");

endmodule

/* dv/tb_gyro_spi_command_master_core.sv */
`timescale 1ns / 1ps
// tb_gyro_spi_command_master_core: self-checking bench for the gyro SPI command master
// depends on gscm_pkg, gscm_in_if, gscm_out_if, gscm_cfg_if and the core

module tb_gyro_spi_command_master_core;
  import gscm_pkg::*;

  localparam int          RANDOM_TICKS   = 300;
  localparam int          RANDOM_SEQS    = 3;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_OFF       = 300;
  localparam int          READ_FRAMES    = 2;
  localparam int          STARTUP_FRAMES = 4;
  localparam logic [2:0]  CMD_SPARE_LO   = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;
  localparam logic [1:0]  CFG_SPARE      = 2'd3;

  typedef enum logic [1:0] {MISO_LOW, MISO_HIGH, MISO_ALT, MISO_RAND} miso_mode_e;

  // one tick offered to the block
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic        miso;
  } tick_t;

  // pin levels and response seen after one tick
  typedef struct packed {
    logic        cs_n;
    logic        sck;
    logic        mosi;
    logic        busy;
    logic        done;
    logic [15:0] value;
    logic [31:0] raw;
  } spi_obs_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } cfg_wr_t;

  // directed row: timing setting, command, sensor reply, optional fixed response
  typedef struct packed {
    logic [15:0] half;
    logic [15:0] gap_s;
    logic [23:0] gap_l;
    logic [2:0]  cmd;
    logic [7:0]  addr;
    logic [15:0] wdata;
    miso_mode_e  miso;
    logic        noisy;
    logic        typed;
    logic [15:0] value;
    logic [31:0] raw;
  } dir_row_t;

  dir_row_t dir_rows [14] = '{
    '{16'd50, 16'd50, 24'd50000, CMD_NONE, 8'h00, 16'h0000, MISO_LOW, 1'b0, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'd1, 16'd1, 24'd1, CMD_WRITE, 8'hFF, 16'hFFFF, MISO_HIGH, 1'b0, 1'b1,
      16'h0000, 32'hFFFF_FFFF},
    '{16'd1, 16'd1, 24'd1, CMD_RATE, 8'h00, 16'h0000, MISO_LOW, 1'b1, 1'b1,
      16'h0000, 32'h0000_0000},
    '{16'd1, 16'd1, 24'd1, CMD_READ, 8'hFF, 16'hFFFF, MISO_HIGH, 1'b1, 1'b1,
      16'hFFFF, 32'hFFFF_FFFF},
    '{16'd1, 16'd5, 24'd9, CMD_READ, 8'hA5, 16'h1234, MISO_RAND, 1'b0, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'd1, 16'd1, 24'd1, CMD_RATE, 8'h3C, 16'h0F0F, MISO_HIGH, 1'b0, 1'b1,
      16'hFFFF, 32'hFFFF_FFFF},
    '{16'd1, 16'd1, 24'd1, CMD_SPARE_LO, 8'hFF, 16'hFFFF, MISO_HIGH, 1'b0, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'd1, 16'd1, 24'd1, CMD_SPARE_HI, 8'h00, 16'h0000, MISO_LOW, 1'b0, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'd0, 16'd0, 24'd0, CMD_READ, 8'h5A, 16'h0000, MISO_ALT, 1'b0, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'd0, 16'd0, 24'd0, CMD_WRITE, 8'h80, 16'h8001, MISO_ALT, 1'b1, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'd1, 16'd3, 24'd6, CMD_STARTUP, 8'h00, 16'h0000, MISO_HIGH, 1'b1, 1'b1,
      16'h0000, 32'hFFFF_FFFF},
    '{16'd2, 16'd2, 24'd3, CMD_WRITE, 8'h7F, 16'h5555, MISO_RAND, 1'b0, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'hFFFF, 16'hFFFF, 24'hFF_FFFF, CMD_NONE, 8'h00, 16'h0000, MISO_LOW, 1'b0, 1'b0,
      16'h0000, 32'h0000_0000},
    '{16'd1, 16'd2, 24'd3, CMD_RATE, 8'h00, 16'h0000, MISO_RAND, 1'b1, 1'b0,
      16'h0000, 32'h0000_0000}
  };

  logic clk;
  logic rst_n;

  gscm_in_if  in_chan ();
  gscm_out_if out_chan ();
  gscm_cfg_if cfg_chan ();

  gyro_spi_command_master_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sequencer copy: timing registers
  logic [15:0] m_half  = HALF_RESET;
  logic [15:0] m_short = SHORT_RESET;
  logic [23:0] m_long  = LONG_RESET;

  // sequencer copy: frame state
  phase_t      m_phase = PH_IDLE;
  cmd_t        m_cmd   = CMD_NONE;
  logic [2:0]  m_frame = '0;
  logic [5:0]  m_bits  = '0;
  logic [23:0] m_wait  = '0;
  logic [31:0] m_tx    = '0;
  logic [31:0] m_rx    = '0;
  logic [31:0] m_word  = '0;
  logic        m_cs    = 1'b1;
  logic        m_sck   = 1'b0;
  logic        m_mosi  = 1'b0;

  spi_obs_t pin_state_q [$];
  cfg_wr_t  cfg_q [$];

  int err_cnt    = 0;
  int out_cnt    = 0;
  int busy_items = 0;
  int cfg_writes = 0;
  int seq_total  = 0;
  int seq_done [8];
  int burst_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 30)
      $display("mismatch at %0t, result %0d: %s want %h got %h", $time, out_cnt, what,
               want, got);
  endtask

  // chip select low, first bit set up, setup wait loaded
  function automatic void open_frame();
    logic [31:0] w;
    w = (m_cmd == CMD_STARTUP) ? ((m_frame == 0) ? WORD_STARTUP0 : WORD_RATE) : m_word;
    m_cs    = 1'b0;
    m_sck   = 1'b0;
    m_mosi  = w[31];
    m_tx    = w << 1;
    m_rx    = '0;
    m_bits  = '0;
    m_wait  = 24'(m_half);
    m_phase = PH_SETUP;
  endfunction

  // sck rises and miso is shifted in
  function automatic void clock_rise(input logic miso);
    m_sck   = 1'b1;
    m_rx    = {m_rx[30:0], miso};
    m_bits  = m_bits + 6'd1;
    m_wait  = 24'(m_half);
    m_phase = PH_HIGH;
  endfunction

  // advance the sequencer by one tick and return the pins after it
  function automatic spi_obs_t step_sensor_link(input tick_t t);
    spi_obs_t o;
    logic     done;
    int       frames;
    done = 1'b0;
    if (m_phase == PH_IDLE) begin
      if (t.cmd >= CMD_WRITE && t.cmd <= CMD_STARTUP) begin
        m_cmd   = cmd_t'(t.cmd);
        m_frame = '0;
        case (m_cmd)
          CMD_WRITE: m_word = WORD_WRITE | (32'(t.addr) << ADDR_LSB) |
                              (32'(t.wdata) << DATA_LSB);
          CMD_READ:  m_word = WORD_READ | (32'(t.addr) << ADDR_LSB);
          default:   m_word = WORD_RATE;
        endcase
        open_frame();
      end
    end else if (m_wait > 1) begin
      m_wait = m_wait - 24'd1;
    end else begin
      case (m_phase)
        PH_SETUP: clock_rise(t.miso);
        PH_HIGH: begin
          m_sck   = 1'b0;
          m_mosi  = m_tx[31];
          m_tx    = m_tx << 1;
          m_wait  = 24'(m_half);
          m_phase = PH_LOW;
        end
        PH_LOW: begin
          if (m_bits < FRAME_BITS) begin
            clock_rise(t.miso);
          end else begin
            // frame over: read and start-up go on after a gap
            m_cs   = 1'b1;
            m_mosi = 1'b0;
            if (m_cmd == CMD_READ && m_frame == 0) begin
              m_wait  = 24'(m_short);
              m_phase = PH_GAP;
            end else if (m_cmd == CMD_STARTUP) begin
              m_wait  = (m_frame == 0) ? 24'(m_short) : m_long;
              m_phase = PH_GAP;
            end else begin
              m_phase = PH_IDLE;
              done    = 1'b1;
            end
          end
        end
        default: begin
          // gap over: next frame or finish
          frames  = (m_cmd == CMD_READ) ? READ_FRAMES :
                    (m_cmd == CMD_STARTUP) ? STARTUP_FRAMES : 1;
          m_frame = m_frame + 3'd1;
          if (m_frame < frames) begin
            open_frame();
          end else begin
            m_phase = PH_IDLE;
            done    = 1'b1;
          end
        end
      endcase
    end
    o.cs_n  = m_cs;
    o.sck   = m_sck;
    o.mosi  = m_mosi;
    o.busy  = (m_phase != PH_IDLE);
    o.done  = done;
    o.value = '0;
    o.raw   = '0;
    if (done) begin
      if (m_cmd == CMD_READ) o.value = m_rx[REG_VALUE_LSB +: 16];
      else if (m_cmd == CMD_RATE) o.value = m_rx[RATE_VALUE_LSB +: 16];
      o.raw = m_rx;
      seq_done[int'(m_cmd)]++;
      seq_total++;
    end
    return o;
  endfunction

  function automatic logic miso_bit(input miso_mode_e mm, input int n);
    case (mm)
      MISO_LOW:  return 1'b0;
      MISO_HIGH: return 1'b1;
      MISO_ALT:  return n[0];
      default:   return 1'($urandom);
    endcase
  endfunction

  // count register value, mostly short so that many sequences fit
  function automatic logic [23:0] pick_count(input int unsigned mid, input int unsigned wide);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 7) return 24'($urandom_range(1, 2));
    if (r < 9) return 24'($urandom_range(2, mid));
    return 24'($urandom_range(mid, wide));
  endfunction

  // offer one tick in bursts with random gaps; predict at the transfer
  task automatic push_tick(input tick_t t, input logic typed = 1'b0,
                           input logic [15:0] tv = '0, input logic [31:0] tr = '0);
    spi_obs_t want;
    logic     fire;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid       <= 1'b1;
    in_chan.cmd         <= t.cmd;
    in_chan.reg_address <= t.addr;
    in_chan.write_data  <= t.wdata;
    in_chan.miso        <= t.miso;
    do begin
      @(negedge clk);
      fire = (in_chan.ready === 1'b1);
      @(posedge clk);
    end while (!fire);
    burst_left--;
    want = step_sensor_link(t);
    if (typed && want.done) begin
      want.value = tv;
      want.raw   = tr;
    end
    if (want.busy || want.done) busy_items++;
    pin_state_q.push_back(want);
  endtask

  // write queued registers once the block is idle and every result is in
  task automatic flush_cfg();
    logic fire;
    if (cfg_q.size() == 0) return;
    in_chan.valid <= 1'b0;
    while (pin_state_q.size() != 0) @(posedge clk);
    while (cfg_q.size() != 0) begin
      cfg_chan.valid     <= 1'b1;
      cfg_chan.reg_index <= cfg_q[0].idx;
      cfg_chan.wdata     <= cfg_q[0].val;
      do begin
        @(negedge clk);
        fire = (cfg_chan.ready === 1'b1);
        @(posedge clk);
      end while (!fire);
      case (cfg_q[0].idx)
        CFG_HALF_PERIOD: m_half  = cfg_q[0].val[15:0];
        CFG_SHORT_GAP:   m_short = cfg_q[0].val[15:0];
        CFG_LONG_GAP:    m_long  = cfg_q[0].val[23:0];
        default: ;
      endcase
      cfg_writes++;
      void'(cfg_q.pop_front());
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // one command and the ticks until the sequencer is idle again
  task automatic run_seq(input logic [2:0] c, input logic [7:0] a, input logic [15:0] d,
                         input miso_mode_e mm, input logic noisy, input logic typed,
                         input logic [15:0] tv, input logic [31:0] tr);
    tick_t t;
    int    n;
    t.cmd   = c;
    t.addr  = a;
    t.wdata = d;
    t.miso  = miso_bit(mm, 0);
    push_tick(t, typed, tv, tr);
    n = 1;
    // commands offered while busy must be dropped
    while (m_phase != PH_IDLE) begin
      t.cmd   = noisy ? 3'($urandom) : CMD_NONE;
      t.addr  = 8'($urandom);
      t.wdata = 16'($urandom);
      t.miso  = miso_bit(mm, n);
      push_tick(t, typed, tv, tr);
      n++;
    end
  endtask

  task automatic run_row(input dir_row_t r);
    if (r.half != m_half || r.gap_s != m_short || r.gap_l != m_long) begin
      cfg_q.push_back('{CFG_HALF_PERIOD, 24'(r.half)});
      cfg_q.push_back('{CFG_SHORT_GAP, 24'(r.gap_s)});
      cfg_q.push_back('{CFG_LONG_GAP, r.gap_l});
      flush_cfg();
    end
    run_seq(r.cmd, r.addr, r.wdata, r.miso, r.noisy, r.typed, r.value, r.raw);
  endtask

  // new timing setting, then a handful of random sequences
  task automatic random_phase();
    logic [23:0] v;
    logic [2:0]  c;
    tick_t       t;
    int          n_seq;
    v = pick_count(3, 5);
    if ($urandom_range(0, 3) != 0) cfg_q.push_back('{CFG_HALF_PERIOD, {8'($urandom), v[15:0]}});
    v = pick_count(3, 8);
    if ($urandom_range(0, 3) != 0) cfg_q.push_back('{CFG_SHORT_GAP, {8'($urandom), v[15:0]}});
    v = pick_count(6, 16);
    if ($urandom_range(0, 3) != 0) cfg_q.push_back('{CFG_LONG_GAP, v});
    if ($urandom_range(0, 7) == 0) cfg_q.push_back('{CFG_SPARE, 24'($urandom)});
    flush_cfg();
    n_seq = $urandom_range(1, 3);
    repeat (n_seq) begin
      // idle ticks with nothing or unused codes
      repeat ($urandom_range(0, 2)) begin
        t.cmd   = ($urandom_range(0, 3) == 0) ? CMD_NONE :
                  3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        t.addr  = 8'($urandom);
        t.wdata = 16'($urandom);
        t.miso  = 1'($urandom);
        push_tick(t);
      end
      c = ($urandom_range(0, 5) == 0) ? CMD_STARTUP : 3'($urandom_range(CMD_WRITE, CMD_RATE));
      run_seq(c, 8'($urandom), 16'($urandom), miso_mode_e'($urandom_range(0, 3)),
              1'($urandom), 1'b0, '0, '0);
    end
  endtask

  // stimulus and end of run
  initial begin
    int dir_seqs;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.cmd         <= CMD_NONE;
    in_chan.reg_address <= '0;
    in_chan.write_data  <= '0;
    in_chan.miso        <= 1'b0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.reg_index  <= CFG_HALF_PERIOD;
    cfg_chan.wdata      <= '0;
    foreach (seq_done[i]) seq_done[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) run_row(dir_rows[i]);

    dir_seqs   = seq_total;
    busy_items = 0;
    while (busy_items < RANDOM_TICKS || seq_total - dir_seqs < RANDOM_SEQS) random_phase();

    in_chan.valid <= 1'b0;
    while (pin_state_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sequences finished: %0d write, %0d read, %0d rate, %0d start-up",
             seq_done[CMD_WRITE], seq_done[CMD_READ], seq_done[CMD_RATE],
             seq_done[CMD_STARTUP]);
    $display("%0d tick results checked, %0d register writes, %0d mismatches",
             out_cnt, cfg_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: stall pattern, long hold-offs, field checks
  initial begin
    logic        fire;
    spi_obs_t    got;
    spi_obs_t    want;
    logic [15:0] stall_pat;
    int          hold_left;
    stall_pat = '0;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      fire = (rst_n === 1'b1) && (out_chan.valid === 1'b1) && (out_chan.ready === 1'b1);
      got.cs_n  = out_chan.cs_n;
      got.sck   = out_chan.sck;
      got.mosi  = out_chan.mosi;
      got.busy  = out_chan.busy_res;
      got.done  = out_chan.done_res;
      got.value = out_chan.read_value;
      got.raw   = out_chan.raw_response;
      @(posedge clk);
      if (fire) begin
        out_cnt++;
        if (pin_state_q.size() == 0) begin
          report_mismatch("result transfer with nothing pending", '0, '0);
        end else begin
          want = pin_state_q.pop_front();
          if (got.cs_n !== want.cs_n) report_mismatch("cs_n", want.cs_n, got.cs_n);
          if (got.sck !== want.sck) report_mismatch("sck", want.sck, got.sck);
          if (got.mosi !== want.mosi) report_mismatch("mosi", want.mosi, got.mosi);
          if (got.busy !== want.busy) report_mismatch("busy_res", want.busy, got.busy);
          if (got.done !== want.done) report_mismatch("done_res", want.done, got.done);
          if (got.value !== want.value) report_mismatch("read_value", want.value, got.value);
          if (got.raw !== want.raw) report_mismatch("raw_response", want.raw, got.raw);
        end
        // back-pressure long enough to fill the block and stall its input
        if (out_cnt == 600 || out_cnt == 1400) hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 127) == 0)
          stall_pat = ($urandom_range(0, 2) == 0) ? '0 : 16'($urandom & $urandom);
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        out_chan.ready <= ~stall_pat[0];
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) ||
          (cfg_chan.valid === 1'b1 && cfg_chan.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending", quiet,
                 pin_state_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
rtl/gscm_pkg.sv
rtl/gscm_in_if.sv
rtl/gscm_out_if.sv
rtl/gscm_cfg_if.sv
rtl/gyro_spi_command_master_core.sv
dv/tb_gyro_spi_command_master_core.sv
